// File: rtl/core/iorr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iorr_pkg
// Shared types and constants for the interrupt override router: request and
// response words, table entry layouts, command and status codes.
// ----------------------------------------------------------------------------
package iorr_pkg;

  // Default table sizes and redirection register base.
  localparam int OVR_ENTRIES_DEF = 16;
  localparam int CTL_ENTRIES_DEF = 8;
  localparam int REDIR_BASE_DEF  = 16;

  localparam int REG_IDX_W = 10;
  localparam int LOW_W     = 17;

  // Command codes.
  localparam logic [1:0] CMD_ROUTE    = 2'd0;
  localparam logic [1:0] CMD_LOAD_OVR = 2'd1;
  localparam logic [1:0] CMD_LOAD_CTL = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_ROUTED = 2'd0;
  localparam logic [1:0] ST_NO_CTL = 2'd1;
  localparam logic [1:0] ST_STORED = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // Override flag bits.
  localparam int FLAG_LOW_POL = 1;
  localparam int FLAG_LEVEL   = 3;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  irq;
    logic [7:0]  src_bus;
    logic [31:0] gsi;
    logic [15:0] flags;
    logic [7:0]  max_entry;
    logic [7:0]  vector;
    logic        mask;
    logic        trig_level;
    logic        pol_low;
    logic        skip_ovr;
  } req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [2:0]           controller;
    logic [REG_IDX_W-1:0] register_index;
    logic [LOW_W-1:0]     low_word;
    logic [31:0]          resolved_gsi;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  bus;
    logic [7:0]  src_irq;
    logic [15:0] flags;
    logic [31:0] gsi;
  } ovr_entry_t;

  typedef struct packed {
    logic [31:0] base;
    logic [7:0]  max_entry;
  } ctl_entry_t;

endpackage

// File: rtl/core/iorr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iorr_ram
// Simple dual-port table memory: one write port, one read port with the
// read data registered.
// ----------------------------------------------------------------------------
module iorr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/core/irq_override_router_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_override_router_top
// Resolves legacy IRQs through an override table and finds the covering
// interrupt controller; both tables live in synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid / req_stall / req) carries one command
//   word: load an override entry, load a controller range, or route an IRQ.
//   The response channel (rsp_valid / rsp_stall / rsp) returns exactly one
//   word per request, in order.
//   A load is accepted in the idle state and moves to the output step,
//   which registers its response word and returns to idle. A route
//   request, unless skip_ovr is set, walks the override table one entry
//   per cycle until the first match or the last loaded entry, then the
//   controller table one entry per cycle until the first range that
//   covers the GSI or the last loaded entry, and then moves to the output
//   step. The walk is set by the single read port of each table memory.
//   req_stall is high while a request is being worked on.
//   A finished response waits in the output register while rsp_stall is
//   high; the next request may be accepted meanwhile, and its response is
//   held back until the output register is free.
//   Reset empties both tables (entry counts to zero) and drops rsp_valid.
// ----------------------------------------------------------------------------
module irq_override_router_top
  import iorr_pkg::*;
#(
  parameter int OVERRIDE_ENTRIES   = OVR_ENTRIES_DEF,
  parameter int CONTROLLER_ENTRIES = CTL_ENTRIES_DEF,
  parameter int REDIRECTION_BASE   = REDIR_BASE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int OVR_AW = (OVERRIDE_ENTRIES > 1) ? $clog2(OVERRIDE_ENTRIES) : 1;
  localparam int OVR_CW = $clog2(OVERRIDE_ENTRIES + 1);
  localparam int CTL_AW = (CONTROLLER_ENTRIES > 1) ? $clog2(CONTROLLER_ENTRIES) : 1;
  localparam int CTL_CW = $clog2(CONTROLLER_ENTRIES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_OVR  = 4'b0010,
    S_CTL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;

  logic [OVR_CW-1:0] ovr_count;
  logic [CTL_CW-1:0] ctl_count;
  logic [OVR_CW-1:0] ovr_idx;
  logic [CTL_CW-1:0] ctl_idx;

  // Working copy of the request being routed.
  logic [7:0]  irq_q;
  logic [7:0]  vector_q;
  logic        mask_q;
  logic        level_q;
  logic        act_low_q;
  logic [31:0] gsi_q;
  logic        route_q;

  logic [1:0]           status_q;
  logic [2:0]           ctl_sel_q;
  logic [REG_IDX_W-1:0] reg_idx_q;

  logic       req_fire;
  logic       out_load;
  logic       ovr_full;
  logic       ctl_full;
  logic       ovr_we;
  logic       ctl_we;
  ovr_entry_t ovr_wdata;
  ctl_entry_t ctl_wdata;
  ovr_entry_t ovr_rdata;
  ctl_entry_t ctl_rdata;
  logic [OVR_AW-1:0] ovr_rd_addr;
  logic [CTL_AW-1:0] ctl_rd_addr;
  logic [OVR_CW-1:0] ovr_idx_inc;
  logic [CTL_CW-1:0] ctl_idx_inc;
  logic       ovr_last;
  logic       ctl_last;

  logic [32:0]          gsi_diff;
  logic                 covers;
  logic [REG_IDX_W-1:0] reg_idx;
  logic [CTL_CW+2:0]    ctl_idx_ext;
  logic [LOW_W-1:0]     low_word;

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign out_load  = (state == S_OUT) && (!rsp_valid || !rsp_stall);

  assign ovr_full = (ovr_count == OVR_CW'(OVERRIDE_ENTRIES));
  assign ctl_full = (ctl_count == CTL_CW'(CONTROLLER_ENTRIES));

  assign ovr_we = req_fire && (req.command == CMD_LOAD_OVR) && !ovr_full;
  assign ctl_we = req_fire && (req.command == CMD_LOAD_CTL) && !ctl_full;

  assign ovr_wdata = '{bus: req.src_bus, src_irq: req.irq, flags: req.flags,
                       gsi: req.gsi};
  assign ctl_wdata = '{base: req.gsi, max_entry: req.max_entry};

  assign ovr_idx_inc = ovr_idx + OVR_CW'(1);
  assign ctl_idx_inc = ctl_idx + CTL_CW'(1);
  assign ovr_last    = (ovr_idx_inc == ovr_count);
  assign ctl_last    = (ctl_idx_inc == ctl_count);

  // Each walk reads one entry ahead; entry 0 is fetched in the cycle before
  // a walk starts, so the data for the current index is always ready.
  assign ovr_rd_addr = (state == S_OVR) ? ovr_idx_inc[OVR_AW-1:0] : '0;
  assign ctl_rd_addr = (state == S_CTL) ? ctl_idx_inc[CTL_AW-1:0] : '0;

  iorr_ram #(
    .WIDTH ($bits(ovr_entry_t)),
    .DEPTH (OVERRIDE_ENTRIES),
    .AW    (OVR_AW)
  ) u_ovr_ram (
    .clk     (clk),
    .wr_en   (ovr_we),
    .wr_addr (ovr_count[OVR_AW-1:0]),
    .wr_data (ovr_wdata),
    .rd_addr (ovr_rd_addr),
    .rd_data (ovr_rdata)
  );

  iorr_ram #(
    .WIDTH ($bits(ctl_entry_t)),
    .DEPTH (CONTROLLER_ENTRIES),
    .AW    (CTL_AW)
  ) u_ctl_ram (
    .clk     (clk),
    .wr_en   (ctl_we),
    .wr_addr (ctl_count[CTL_AW-1:0]),
    .wr_data (ctl_wdata),
    .rd_addr (ctl_rd_addr),
    .rd_data (ctl_rdata)
  );

  // Coverage test is done at 33 bits so the upper bound never wraps.
  assign gsi_diff = {1'b0, gsi_q} - {1'b0, ctl_rdata.base};
  assign covers   = !gsi_diff[32] && (gsi_diff[31:8] == 24'd0) &&
                    (gsi_diff[7:0] <= ctl_rdata.max_entry);
  assign reg_idx  = REG_IDX_W'(REDIRECTION_BASE) +
                    REG_IDX_W'({gsi_diff[7:0], 1'b0});
  assign ctl_idx_ext = {3'b000, ctl_idx};

  assign low_word = {mask_q, level_q, 1'b0, act_low_q, 5'b00000, vector_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ovr_count <= '0;
      ctl_count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            irq_q     <= req.irq;
            vector_q  <= req.vector;
            mask_q    <= req.mask;
            level_q   <= req.trig_level;
            act_low_q <= req.pol_low;
            gsi_q     <= {24'd0, req.irq};
            route_q   <= (req.command == CMD_ROUTE);
            ctl_sel_q <= '0;
            reg_idx_q <= '0;
            ovr_idx   <= '0;
            ctl_idx   <= '0;
            case (req.command)
              CMD_ROUTE: begin
                status_q <= ST_NO_CTL;
                if (!req.skip_ovr && (ovr_count != '0)) begin
                  state <= S_OVR;
                end else if (ctl_count != '0) begin
                  state <= S_CTL;
                end else begin
                  state <= S_OUT;
                end
              end
              CMD_LOAD_OVR: begin
                status_q <= ovr_full ? ST_FULL : ST_STORED;
                if (!ovr_full) begin
                  ovr_count <= ovr_count + OVR_CW'(1);
                end
                state <= S_OUT;
              end
              CMD_LOAD_CTL: begin
                status_q <= ctl_full ? ST_FULL : ST_STORED;
                if (!ctl_full) begin
                  ctl_count <= ctl_count + CTL_CW'(1);
                end
                state <= S_OUT;
              end
              default: begin
                status_q <= ST_FULL;
                state    <= S_OUT;
              end
            endcase
          end
        end
        S_OVR: begin
          if (ovr_rdata.src_irq == irq_q) begin
            gsi_q <= ovr_rdata.gsi;
            // Only an ISA-bus override replaces the requested polarity/trigger.
            if (ovr_rdata.bus == 8'd0) begin
              act_low_q <= ovr_rdata.flags[FLAG_LOW_POL];
              level_q   <= ovr_rdata.flags[FLAG_LEVEL];
            end
          end
          if ((ovr_rdata.src_irq == irq_q) || ovr_last) begin
            state <= (ctl_count != '0) ? S_CTL : S_OUT;
          end else begin
            ovr_idx <= ovr_idx_inc;
          end
        end
        S_CTL: begin
          if (covers) begin
            status_q  <= ST_ROUTED;
            ctl_sel_q <= ctl_idx_ext[2:0];
            reg_idx_q <= reg_idx;
            state     <= S_OUT;
          end else if (ctl_last) begin
            state <= S_OUT;
          end else begin
            ctl_idx <= ctl_idx_inc;
          end
        end
        S_OUT: begin
          if (out_load) begin
            rsp.status         <= status_q;
            rsp.controller     <= ctl_sel_q;
            rsp.register_index <= reg_idx_q;
            rsp.low_word       <= route_q ? low_word : '0;
            rsp.resolved_gsi   <= route_q ? gsi_q : '0;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The table counts never pass their capacity.
  a_ovr_count_bound: assert property (@(posedge clk) disable iff (rst)
    ovr_count <= OVR_CW'(OVERRIDE_ENTRIES))
    else $error("override count beyond table size");

  a_ctl_count_bound: assert property (@(posedge clk) disable iff (rst)
    ctl_count <= CTL_CW'(CONTROLLER_ENTRIES))
    else $error("controller count beyond table size");

  // A walk only looks at entries that have been loaded.
  a_ovr_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_OVR) |-> (ovr_idx < ovr_count))
    else $error("override walk past loaded entries");

  a_ctl_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CTL) |-> (ctl_idx < ctl_count))
    else $error("controller walk past loaded entries");

  // A new response word appears only after the sequencer finished a request.
  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_OUT && state == S_IDLE))
    else $error("response raised outside of the output step");

endmodule
